@@ design/sfpp_pkg.sv @@
package sfpp_pkg;

  // field widths
  localparam int CH_W       = 4;
  localparam int BYTE_W     = 8;
  localparam int RAW_W      = 16;
  localparam int SCALED_W   = 22;
  localparam int VALUE_W    = 23;
  localparam int DIR_W      = 5;
  localparam int OUT_DATA_W = 56;

  // input request kinds carried on tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  // direction offset for negative values
  localparam logic [DIR_W-1:0] NEG_DIR_ADD = 5'd6;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_ARM    = 1'b1
  } cmd_e;

  // classified request passed from the parser to the datapath
  typedef struct packed {
    cmd_e             kind;
    logic [CH_W-1:0]  ch;
    logic [RAW_W-1:0] raw;
    logic             last;
  } cmd_t;

endpackage

@@ design/sfpp_front.sv @@
module sfpp_front #(
  parameter int CHANNELS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       opcode_i,
  input  logic [sfpp_pkg::BYTE_W-1:0] data_byte_i,
  output logic                       push_o,
  output sfpp_pkg::cmd_t             cmd_o
);
  import sfpp_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;

  // parser phases
  localparam logic [1:0] PH_SYNC1 = 2'd0;
  localparam logic [1:0] PH_SYNC2 = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;
  localparam logic [1:0] PH_LOW   = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [BYTE_W-1:0] high_q, high_d;
  logic              accept;
  logic              last;

  assign accept = in_valid_i && in_ready_i;
  assign last   = (cnt_q == LAST_IDX);

  // sync hunt, byte pairing and classification
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    high_d      = high_q;
    push_o      = 1'b0;
    cmd_o.kind  = CMD_SAMPLE;
    cmd_o.ch    = CH_W'(cnt_q);
    cmd_o.raw   = {high_q, data_byte_i};
    cmd_o.last  = last;
    if (accept) begin
      if (opcode_i == OP_ARM) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_ARM;
      end else begin
        unique case (phase_q)
          PH_SYNC1: begin
            if (data_byte_i == SYNC_BYTE) phase_d = PH_SYNC2;
          end
          PH_SYNC2: begin
            phase_d = (data_byte_i == SYNC_BYTE) ? PH_HIGH : PH_SYNC1;
          end
          PH_HIGH: begin
            high_d  = data_byte_i;
            phase_d = PH_LOW;
          end
          PH_LOW: begin
            push_o = 1'b1;
            if (last) begin
              cnt_d   = '0;
              phase_d = PH_SYNC1;
            end else begin
              cnt_d   = cnt_q + IDX_W'(1);
              phase_d = PH_HIGH;
            end
          end
          default: phase_d = PH_SYNC1;
        endcase
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      cnt_q   <= '0;
      high_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      high_q  <= high_d;
    end
  end

  // a frame's last sample restarts the channel count
  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && cmd_o.kind == CMD_SAMPLE && cmd_o.last |=> cnt_q == '0)
    else $error("channel count did not wrap after frame end");

endmodule

@@ design/sfpp_queue.sv @@
module sfpp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfpp_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sfpp_pkg::cmd_t cmd_o
);
  import sfpp_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push;
  logic       do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= cmd_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // the parser must hold off while the queue is full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into full queue");

endmodule

@@ design/sfpp_back.sv @@
module sfpp_back #(
  parameter int CHANNELS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  sfpp_pkg::cmd_t                    q_cmd_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sfpp_pkg::CH_W-1:0]         out_ch_o,
  output logic signed [sfpp_pkg::VALUE_W-1:0] out_value_o,
  output logic                              out_last_o,
  output logic [sfpp_pkg::SCALED_W-1:0]     out_peak_o,
  output logic [sfpp_pkg::DIR_W-1:0]        out_dir_o
);
  import sfpp_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [SCALED_W-1:0] offset_q [CHANNELS];
  logic [SCALED_W-1:0] raw_q    [CHANNELS];

  // stage 1: scaled sample and offset-corrected value
  logic                      s1_valid_q;
  logic                      s1_arm_q;
  logic [IDX_W-1:0]          s1_idx_q;
  logic                      s1_last_q;
  logic [SCALED_W-1:0]       s1_scaled_q;
  logic signed [VALUE_W-1:0] s1_sv_q;
  logic                      s1_adv;
  logic                      s1_sample_adv;
  logic                      s1_frame_last;

  // running peak and capture request
  logic [SCALED_W-1:0] peak_q;
  logic [DIR_W-1:0]    dir_q;
  logic                armed_q;

  // output register
  logic                      out_valid_q;
  logic [CH_W-1:0]           out_ch_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                      out_last_q;
  logic [SCALED_W-1:0]       out_peak_q;
  logic [DIR_W-1:0]          out_dir_q;

  logic [IDX_W-1:0]          pop_idx;
  logic [SCALED_W-1:0]       scaled_w;
  logic signed [VALUE_W-1:0] sv_w;
  logic                      neg;
  logic [VALUE_W-1:0]        mag_full;
  logic [SCALED_W-1:0]       mag;
  logic                      gt;
  logic [SCALED_W-1:0]       new_peak;
  logic [DIR_W-1:0]          new_dir;
  logic                      capture;

  // handshake between stages; the request after a frame end is held until the
  // frame end leaves stage 1, so that it sees offsets after a capture
  assign s1_frame_last = s1_valid_q && !s1_arm_q && s1_last_q;
  assign s1_adv        = s1_valid_q && (s1_arm_q || !out_valid_q || out_ready_i);
  assign s1_sample_adv = s1_adv && !s1_arm_q;
  assign q_pop_o       = q_valid_i && (!s1_valid_q || (s1_adv && !s1_frame_last));

  // raw*33 by shift and add, then offset subtract
  assign pop_idx  = q_cmd_i.ch[IDX_W-1:0];
  assign scaled_w = SCALED_W'({q_cmd_i.raw, 5'b0}) + SCALED_W'(q_cmd_i.raw);
  assign sv_w     = $signed({1'b0, scaled_w}) - $signed({1'b0, offset_q[pop_idx]});

  // magnitude and peak compare
  assign neg      = s1_sv_q[VALUE_W-1];
  assign mag_full = neg ? VALUE_W'(-s1_sv_q) : VALUE_W'(s1_sv_q);
  assign mag      = mag_full[SCALED_W-1:0];
  assign gt       = (mag > peak_q);
  assign new_peak = gt ? mag : peak_q;
  assign new_dir  = gt ? (DIR_W'(s1_idx_q) + (neg ? NEG_DIR_ADD : '0)) : dir_q;
  assign capture  = s1_sample_adv && s1_last_q && armed_q;

  // stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_arm_q    <= (q_cmd_i.kind == CMD_ARM);
      s1_idx_q    <= pop_idx;
      s1_last_q   <= q_cmd_i.last;
      s1_scaled_q <= scaled_w;
      s1_sv_q     <= sv_w;
    end
  end

  // frame raw values, written per sample
  always_ff @(posedge clk_i) begin
    if (s1_sample_adv) raw_q[s1_idx_q] <= s1_scaled_q;
  end

  // offsets, copied from the frame at a capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CHANNELS; k++) offset_q[k] <= '0;
    end else if (capture) begin
      for (int k = 0; k < CHANNELS; k++) begin
        offset_q[k] <= (IDX_W'(k) == s1_idx_q) ? s1_scaled_q : raw_q[k];
      end
    end
  end

  // peak tracking and capture arming
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      dir_q   <= '0;
      armed_q <= 1'b0;
    end else if (s1_adv) begin
      if (s1_arm_q) begin
        armed_q <= 1'b1;
      end else if (s1_last_q) begin
        peak_q  <= '0;
        dir_q   <= '0;
        armed_q <= 1'b0;
      end else begin
        peak_q <= new_peak;
        dir_q  <= new_dir;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_sample_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_sample_adv) begin
      out_ch_q    <= CH_W'(s1_idx_q);
      out_value_q <= s1_sv_q;
      out_last_q  <= s1_last_q;
      out_peak_q  <= s1_last_q ? new_peak : '0;
      out_dir_q   <= s1_last_q ? new_dir : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ch_o    = out_ch_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;
  assign out_peak_o  = out_peak_q;
  assign out_dir_o   = out_dir_q;

  // peak fields only carry data on the frame's last channel
  a_peak_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_peak_q == '0 && out_dir_q == '0)
    else $error("peak reported before frame end");

  // a frame end always disarms capture and clears the running peak
  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_sample_adv && s1_last_q |=> !armed_q && peak_q == '0 && dir_q == '0)
    else $error("frame end left capture or peak state behind");

endmodule

@@ design/sensor_frame_parser_peak.sv @@
// a result passes the queue entry, stage 1 and the output register before m_axis
// throughput: one request per cycle while the queue is not full; the datapath
//   holds back the request after a frame's last channel so it sees updated offsets
// a two-entry queue between parser and datapath lets each side stall alone
// reset: asynchronous, active low; parser waits for sync, offsets and peak zero
module sensor_frame_parser_peak #(
  parameter int CHANNELS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sfpp_pkg::BYTE_W-1:0]         s_axis_tdata,  // data_byte
  input  logic                                s_axis_tuser,  // opcode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // channel[3:0], value[26:4], peak_value[48:27], peak_direction[53:49], zero
  output logic [sfpp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast   // frame_end
);
  import sfpp_pkg::*;

  logic                      push;
  cmd_t                      push_cmd;
  logic                      q_full;
  logic                      q_valid;
  logic                      q_pop;
  cmd_t                      q_cmd;
  logic [CH_W-1:0]           out_ch;
  logic signed [VALUE_W-1:0] out_value;
  logic [SCALED_W-1:0]       out_peak;
  logic [DIR_W-1:0]          out_dir;

  assign s_axis_tready = !q_full;

  // sync hunt and request classification
  sfpp_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .opcode_i    (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // decoupling queue
  sfpp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // scaling, offset correction, peak tracking
  sfpp_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ch_o    (out_ch),
    .out_value_o (out_value),
    .out_last_o  (m_axis_tlast),
    .out_peak_o  (out_peak),
    .out_dir_o   (out_dir)
  );

  // pack result fields
  assign m_axis_tdata = {2'b00, out_dir, out_peak, out_value, out_ch};

endmodule

@@ test/frame_result_checker.sv @@
module frame_result_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [sfpp_pkg::BYTE_W-1:0]     s_axis_tdata,   // data_byte
  input  logic                            s_axis_tuser,   // opcode
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // channel[3:0], value[26:4], peak_value[48:27], peak_direction[53:49], zero
  input  logic [sfpp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            m_axis_tlast,   // frame_end
  output int                              errors_o,
  output int                              pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import sfpp_pkg::*;

  localparam int               NCH       = 12;
  localparam int               Q12_SCALE = 33;
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam int               MAX_LINES = 40;

  typedef enum logic [1:0] {
    HUNT_SYNC1,
    HUNT_SYNC2,
    TAKE_HIGH,
    TAKE_LOW
  } parse_phase_e;

  typedef struct packed {
    logic [CH_W-1:0]     ch;
    logic [VALUE_W-1:0]  value;
    logic                last;
    logic [SCALED_W-1:0] peak;
    logic [DIR_W-1:0]    dir;
  } sample_result_t;

  parse_phase_e         phase;
  logic [CH_W-1:0]      ch_idx;
  logic [BYTE_W-1:0]    hi_byte;
  logic [SCALED_W-1:0]  offsets [NCH];
  logic [SCALED_W-1:0]  frame_scaled [NCH];
  logic [SCALED_W-1:0]  peak_mag;
  logic [DIR_W-1:0]     peak_dir;
  logic                 armed;
  sample_result_t       expected_samples [$];
  int                   errors;

  // parser and offset store after reset
  task automatic clear_state();
    phase    = HUNT_SYNC1;
    ch_idx   = '0;
    hi_byte  = '0;
    peak_mag = '0;
    peak_dir = '0;
    armed    = 1'b0;
    for (int k = 0; k < NCH; k++) begin
      offsets[k]      = '0;
      frame_scaled[k] = '0;
    end
    expected_samples.delete();
    errors = 0;
  endtask

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    if (errors < MAX_LINES) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    end
    errors++;
  endtask

  // advance the parser by one accepted request, queue the sample it completes
  task automatic parse_request(input logic op, input logic [BYTE_W-1:0] b);
    int             idx;
    int             scaled;
    int             diff;
    int             mag;
    logic           neg;
    sample_result_t res;
    if (op == OP_ARM) begin
      armed = 1'b1;
      return;
    end
    case (phase)
      HUNT_SYNC1: begin
        if (b == SYNC_BYTE) phase = HUNT_SYNC2;
      end
      HUNT_SYNC2: begin
        phase = (b == SYNC_BYTE) ? TAKE_HIGH : HUNT_SYNC1;
      end
      TAKE_HIGH: begin
        hi_byte = b;
        phase   = TAKE_LOW;
      end
      default: begin
        idx    = (ch_idx >= NCH) ? 0 : int'(ch_idx);
        scaled = int'({hi_byte, b}) * Q12_SCALE;
        frame_scaled[idx] = SCALED_W'(scaled);
        diff   = scaled - int'(offsets[idx]);
        neg    = diff < 0;
        mag    = neg ? -diff : diff;
        // strict compare keeps the first of equal magnitudes
        if (mag > int'(peak_mag)) begin
          peak_mag = SCALED_W'(mag);
          peak_dir = DIR_W'(idx) + (neg ? NEG_DIR_ADD : DIR_W'(0));
        end
        res.ch    = CH_W'(idx);
        res.value = VALUE_W'(diff);
        res.last  = (idx + 1) >= NCH;
        res.peak  = '0;
        res.dir   = '0;
        if (res.last) begin
          // capture uses this frame's scaled raw values, effective next frame
          if (armed) begin
            offsets = frame_scaled;
            armed   = 1'b0;
          end
          res.peak = peak_mag;
          res.dir  = peak_dir;
          peak_mag = '0;
          peak_dir = '0;
          ch_idx   = '0;
          phase    = HUNT_SYNC1;
        end else begin
          ch_idx = CH_W'(idx + 1);
          phase  = TAKE_HIGH;
        end
        expected_samples.push_back(res);
      end
    endcase
  endtask

  // compare one accepted result with the oldest expectation
  task automatic check_result();
    sample_result_t exp_r;
    if (expected_samples.size() == 0) begin
      report_mismatch("unexpected result, channel", -1, longint'(m_axis_tdata[3:0]));
      return;
    end
    exp_r = expected_samples.pop_front();
    if (m_axis_tdata[3:0] !== exp_r.ch)
      report_mismatch("channel", exp_r.ch, m_axis_tdata[3:0]);
    if (m_axis_tdata[26:4] !== exp_r.value)
      report_mismatch("value", longint'($signed(exp_r.value)),
                      longint'($signed(m_axis_tdata[26:4])));
    if (m_axis_tlast !== exp_r.last)
      report_mismatch("frame_end", exp_r.last, m_axis_tlast);
    if (m_axis_tdata[48:27] !== exp_r.peak)
      report_mismatch("peak_value", exp_r.peak, m_axis_tdata[48:27]);
    if (m_axis_tdata[53:49] !== exp_r.dir)
      report_mismatch("peak_direction", exp_r.dir, m_axis_tdata[53:49]);
    if (m_axis_tdata[OUT_DATA_W-1:54] !== '0)
      report_mismatch("padding bits", 0, m_axis_tdata[OUT_DATA_W-1:54]);
  endtask

  // watch both channels at each edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) parse_request(s_axis_tuser, s_axis_tdata);
    end
    errors_o  <= errors;
    pending_o <= expected_samples.size();
  end

endmodule

@@ test/tb_sensor_frame_parser_peak.sv @@
module tb_sensor_frame_parser_peak;

  timeunit 1ns;
  timeprecision 1ps;

  import sfpp_pkg::*;

  localparam int NCH        = 12;
  localparam int ITEM_GOAL  = 1800;
  localparam int IDLE_LIMIT = 600;
  localparam int MAX_GAP    = 18;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  int                    errors;
  int                    pending;

  bit                    no_idle;
  int                    items;
  int                    idle_cycles;
  logic [RAW_W-1:0]      frame_raw [NCH];

  always #6 clk_i = ~clk_i;

  sensor_frame_parser_peak #(
    .CHANNELS(NCH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  frame_result_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // one request, with a random gap ahead of it; valid stays high across back-to-back requests
  task automatic send_req(input logic op, input logic [BYTE_W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items++;
  endtask

  task automatic send_arm();
    send_req(OP_ARM, BYTE_W'($urandom));
  endtask

  // sync pair then twelve big-endian samples; arm_at < 0 means no arm inside
  task automatic send_frame(input int arm_at);
    send_req(OP_BYTE, 8'hFF);
    send_req(OP_BYTE, 8'hFF);
    for (int ch = 0; ch < NCH; ch++) begin
      if (arm_at == ch) send_arm();
      send_req(OP_BYTE, frame_raw[ch][15:8]);
      send_req(OP_BYTE, frame_raw[ch][7:0]);
    end
  endtask

  // hold the sender until every expected result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // raw sample patterns for one frame
  task automatic fill_frame(input int mode);
    logic [RAW_W-1:0] same;
    same = RAW_W'($urandom);
    for (int ch = 0; ch < NCH; ch++) begin
      case (mode)
        0: frame_raw[ch] = RAW_W'($urandom);
        1: begin
          case ($urandom_range(0, 6))
            0:       frame_raw[ch] = 16'h0000;
            1:       frame_raw[ch] = 16'hFFFF;
            2:       frame_raw[ch] = 16'h00FF;
            3:       frame_raw[ch] = 16'hFF00;
            4:       frame_raw[ch] = 16'h8000;
            5:       frame_raw[ch] = 16'h7FFF;
            default: frame_raw[ch] = 16'h0001;
          endcase
        end
        2: frame_raw[ch] = same;
        3: frame_raw[ch] = RAW_W'($urandom_range(0, 300));
        default: frame_raw[ch] = RAW_W'(1) << $urandom_range(0, 15);
      endcase
    end
  endtask

  // receiver: random stall before each result
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", pending);
        $display("tb_sensor_frame_parser_peak failed");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int  r;
    int  iter;
    bit  drained_mid;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_BYTE;
    m_axis_tready = 1'b0;
    no_idle       = 1'b0;
    items         = 0;
    iter          = 0;
    drained_mid   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // noise before sync, then a broken sync pair
    send_req(OP_BYTE, 8'h00);
    send_req(OP_BYTE, 8'hFF);
    send_req(OP_BYTE, 8'h5A);
    send_req(OP_BYTE, 8'hAA);

    // all-zero frame: peak zero, direction zero
    for (int ch = 0; ch < NCH; ch++) frame_raw[ch] = '0;
    send_frame(-1);

    // full-scale frame, sync value inside data, all magnitudes tied
    for (int ch = 0; ch < NCH; ch++) frame_raw[ch] = 16'hFFFF;
    send_frame(-1);

    // arm twice, ramp frame captures offsets but still uses the old ones
    send_arm();
    send_arm();
    for (int ch = 0; ch < NCH; ch++)
      frame_raw[ch] = (ch == NCH - 1) ? 16'hFFFF : RAW_W'(ch * 16'h1357);
    send_frame(-1);

    // zero frame against the ramp offsets: zero or negative values, most negative on the last
    for (int ch = 0; ch < NCH; ch++) frame_raw[ch] = '0;
    send_frame(-1);

    // arm mid-frame, then a frame that sees the new offsets
    fill_frame(0);
    send_frame(5);
    fill_frame(1);
    send_frame(-1);
    drain();

    // random traffic, mostly well-formed frames
    while (items < ITEM_GOAL) begin
      iter++;
      if (iter % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        repeat ($urandom_range(1, 6)) begin
          send_req(OP_BYTE, ($urandom_range(0, 3) == 0) ? 8'hFF : BYTE_W'($urandom));
        end
      end else if (r < 10) begin
        send_req(OP_BYTE, 8'hFF);
        send_req(OP_BYTE, BYTE_W'($urandom_range(0, 254)));
      end else if (r < 13) begin
        // frame cut short, the parser eats the next sync as data
        send_req(OP_BYTE, 8'hFF);
        send_req(OP_BYTE, 8'hFF);
        repeat ($urandom_range(1, 2 * NCH - 1)) send_req(OP_BYTE, BYTE_W'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) send_arm();
        fill_frame($urandom_range(0, 4));
        send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(0, NCH - 1) : -1);
      end
      if ((!drained_mid && items >= ITEM_GOAL / 2) || $urandom_range(0, 40) == 0) begin
        drained_mid = 1'b1;
        drain();
      end
    end

    no_idle = 1'b0;
    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_sensor_frame_parser_peak passed");
    end else begin
      $display("tb_sensor_frame_parser_peak failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/sfpp_pkg.sv
design/sfpp_front.sv
design/sfpp_queue.sv
design/sfpp_back.sv
design/sensor_frame_parser_peak.sv
test/frame_result_checker.sv
test/tb_sensor_frame_parser_peak.sv
